// File: rtl/i2cms_pkg.sv
// Shared types and constants for the I2C master transfer sequencer.
package i2cms_pkg;

    // Transmit buffer: depth is a power of two, positions wrap on the index bits.
    localparam int BUF_IDX_W = 8;
    localparam int BUF_DEPTH = 2 ** BUF_IDX_W;

    localparam int FUNC_W = 2;

    // Item kinds carried on s_tuser.
    localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REQ    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_STATUS = 2'd2;

    // Bus status codes after masking.
    localparam logic [7:0] ST_MASK       = 8'hF8;
    localparam logic [7:0] ST_START      = 8'h08;
    localparam logic [7:0] ST_RSTART     = 8'h10;
    localparam logic [7:0] ST_SLAW_ACK   = 8'h18;
    localparam logic [7:0] ST_SLAW_NACK  = 8'h20;
    localparam logic [7:0] ST_DATA_ACK   = 8'h28;
    localparam logic [7:0] ST_DATA_NACK  = 8'h30;
    localparam logic [7:0] ST_SLAR_ACK   = 8'h40;
    localparam logic [7:0] ST_SLAR_NACK  = 8'h48;
    localparam logic [7:0] ST_RXD_ACK    = 8'h50;
    localparam logic [7:0] ST_RXD_NACK   = 8'h58;

    typedef enum logic [2:0] {
        ACT_NONE   = 3'd0,
        ACT_SEND   = 3'd1,
        ACT_START  = 3'd2,
        ACT_STOP   = 3'd3,
        ACT_RDACK  = 3'd4,
        ACT_RDNACK = 3'd5
    } act_t;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'b001,
        MODE_WR   = 3'b010,
        MODE_RD   = 3'b100
    } mode_t;

    // Input word payload, first declared field in the highest bits.
    typedef struct packed {
        logic [7:0] bus_rx_byte;
        logic [7:0] status_code;
        logic [7:0] load_byte;
        logic [7:0] load_index;
        logic [7:0] read_count;
        logic [7:0] write_count;
        logic [7:0] slave_addr;
    } s_data_t;

    localparam int S_DATA_W = $bits(s_data_t);

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        s_data_t           d;
    } item_t;

    // Result word, first declared field in the highest bits.
    typedef struct packed {
        logic       busy;
        logic       aborted;
        logic       done;
        logic [7:0] rx_byte;
        logic [7:0] rx_index;
        logic       rx_valid;
        logic [7:0] bus_byte;
        act_t       bus_action;
        logic       accepted;
    } result_t;

    localparam int M_DATA_W = $bits(result_t);

    typedef struct packed {
        mode_t      mode;
        logic [7:0] target_addr;
        logic [7:0] writes_total;
        logic [7:0] reads_total;
        logic [7:0] position;
    } seq_state_t;

endpackage

// File: rtl/i2cms_step.sv
// Next-state and result decode for one sequencer word.
module i2cms_step (
    input  i2cms_pkg::item_t      item,
    input  i2cms_pkg::seq_state_t st,
    input  logic [7:0]            rd_byte,
    output i2cms_pkg::seq_state_t st_next,
    output i2cms_pkg::result_t    res
);
    import i2cms_pkg::*;

    logic [7:0] code;
    logic [7:0] pos_inc;

    always_comb begin
        code    = item.d.status_code & ST_MASK;
        pos_inc = st.position + 8'd1;
        st_next = st;
        res     = '0;
        res.bus_action = ACT_NONE;

        unique case (item.func)
            FUNC_LOAD: begin
                // buffer write happens at accept time
            end
            FUNC_REQ: begin
                if (st.mode == MODE_IDLE) begin
                    res.accepted         = 1'b1;
                    res.bus_action       = ACT_START;
                    st_next.writes_total = item.d.write_count;
                    st_next.reads_total  = item.d.read_count;
                    st_next.position     = 8'd0;
                    if (item.d.write_count != 8'd0) begin
                        st_next.mode        = MODE_WR;
                        st_next.target_addr = item.d.slave_addr;
                    end else begin
                        st_next.mode        = MODE_RD;
                        st_next.target_addr = item.d.slave_addr | 8'h01;
                    end
                end
            end
            FUNC_STATUS: begin
                if (st.mode != MODE_IDLE) begin
                    unique case (code) inside
                        ST_START: begin
                            res.bus_action = ACT_SEND;
                            res.bus_byte   = st.target_addr;
                        end
                        ST_RSTART: begin
                            res.bus_action = ACT_SEND;
                            res.bus_byte   = st.target_addr | 8'h01;
                        end
                        ST_SLAW_ACK, ST_DATA_ACK: begin
                            if (st.mode == MODE_WR) begin
                                if (st.position < st.writes_total) begin
                                    res.bus_action   = ACT_SEND;
                                    res.bus_byte     = rd_byte;
                                    st_next.position = pos_inc;
                                end else if (st.reads_total != 8'd0) begin
                                    res.bus_action   = ACT_START;
                                    st_next.position = 8'd0;
                                    st_next.mode     = MODE_RD;
                                end else begin
                                    res.bus_action = ACT_STOP;
                                    res.done       = 1'b1;
                                    st_next.mode   = MODE_IDLE;
                                end
                            end
                        end
                        ST_SLAR_ACK: begin
                            // single-byte read is NACKed right away
                            res.bus_action = (st.reads_total > 8'd1) ? ACT_RDACK : ACT_RDNACK;
                        end
                        ST_RXD_ACK: begin
                            if (st.position < st.reads_total) begin
                                res.rx_valid = 1'b1;
                                res.rx_index = st.position;
                                res.rx_byte  = item.d.bus_rx_byte;
                            end
                            st_next.position = pos_inc;
                            res.bus_action = (({1'b0, pos_inc} + 9'd1) < {1'b0, st.reads_total})
                                           ? ACT_RDACK : ACT_RDNACK;
                        end
                        ST_RXD_NACK: begin
                            if (st.position < st.reads_total) begin
                                res.rx_valid = 1'b1;
                                res.rx_index = st.position;
                                res.rx_byte  = item.d.bus_rx_byte;
                            end
                            st_next.position = pos_inc;
                            res.bus_action   = ACT_STOP;
                            res.done         = 1'b1;
                            st_next.mode     = MODE_IDLE;
                        end
                        ST_SLAW_NACK, ST_DATA_NACK, ST_SLAR_NACK: begin
                            res.bus_action = ACT_STOP;
                            res.aborted    = 1'b1;
                            st_next.mode   = MODE_IDLE;
                        end
                        default: begin
                            // unknown status: no action
                        end
                    endcase
                end
            end
            default: begin
                // unused kind: no action
            end
        endcase

        res.busy = (st_next.mode != MODE_IDLE);
    end

endmodule

// File: rtl/i2c_master_transfer_sequencer.sv
// I2C master transfer sequencer top level: buffer RAM, decode stage, output register.
// A word accepted into the decode holding register moves to the output register when that is free or draining.
// Throughput: one word per cycle while m_tready does not stall the output; the transmit buffer RAM read is
// overlapped with the previous word's decode through position forwarding.
// Reset: aresetn low, synchronous; clears mode to idle, counters and both valid flags.
// The transmit buffer is not cleared; unwritten entries read as unknown.
module i2c_master_transfer_sequencer (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // slave_addr, write_count, read_count, load_index, load_byte, status_code, bus_rx_byte
    input  logic [i2cms_pkg::S_DATA_W-1:0]    s_tdata,
    // func
    input  logic [i2cms_pkg::FUNC_W-1:0]      s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // accepted, bus_action, bus_byte, rx_valid, rx_index, rx_byte, done, aborted, busy
    output logic [i2cms_pkg::M_DATA_W-1:0]    m_tdata
);
    import i2cms_pkg::*;

    // transmit buffer, single port, registered read
    logic [7:0] tx_mem [BUF_DEPTH];
    logic [7:0] rd_byte_reg;

    // decode stage holding register
    logic       a_valid_reg;
    item_t      a_item_reg;

    seq_state_t st_reg;
    seq_state_t st_next;
    result_t    res;

    logic       m_valid_reg;
    result_t    m_data_reg;

    item_t                in_item;
    logic                 s_acc;
    logic                 a_adv;
    logic [BUF_IDX_W-1:0] rd_addr;

    assign in_item.func = s_tuser;
    assign in_item.d    = s_data_t'(s_tdata);

    // decode stage moves on whenever the output register is free or draining
    assign a_adv    = a_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !a_valid_reg || a_adv;
    assign s_acc    = s_tvalid && s_tready;

    // read at the position the word in decode leaves behind
    assign rd_addr = a_adv ? st_next.position[BUF_IDX_W-1:0]
                           : st_reg.position[BUF_IDX_W-1:0];

    // loads write in order at accept, so a later read always sees them
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            if (in_item.func == FUNC_LOAD) begin
                tx_mem[in_item.d.load_index[BUF_IDX_W-1:0]] <= in_item.d.load_byte;
            end else begin
                rd_byte_reg <= tx_mem[rd_addr];
            end
        end
    end

    i2cms_step u_step (
        .item    (a_item_reg),
        .st      (st_reg),
        .rd_byte (rd_byte_reg),
        .st_next (st_next),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            a_item_reg <= in_item;
        end
        if (a_adv) begin
            m_data_reg <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg         <= 1'b0;
            m_valid_reg         <= 1'b0;
            st_reg.mode         <= MODE_IDLE;
            st_reg.target_addr  <= 8'd0;
            st_reg.writes_total <= 8'd0;
            st_reg.reads_total  <= 8'd0;
            st_reg.position     <= 8'd0;
        end else begin
            if (s_acc) begin
                a_valid_reg <= 1'b1;
            end else if (a_adv) begin
                a_valid_reg <= 1'b0;
            end
            if (a_adv) begin
                m_valid_reg <= 1'b1;
                st_reg      <= st_next;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// File: rtl/i2cms_checker.sv
// Port-level checks for the I2C master transfer sequencer, bound to the top level.
module i2cms_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [i2cms_pkg::M_DATA_W-1:0] m_tdata
);
    import i2cms_pkg::*;

    result_t r;
    assign r = result_t'(m_tdata);

    // a stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // a taken request always opens with start and leaves the sequencer busy
    a_req: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && r.accepted |-> r.bus_action == ACT_START && r.busy)
        else $error("accepted request without start or busy");

    // completion and abort always come with stop and an idle sequencer
    a_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (r.done || r.aborted) |->
            r.bus_action == ACT_STOP && !r.busy && !(r.done && r.aborted))
        else $error("bad transfer end word");

    // received bytes only with a read action or the final stop
    a_rx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && r.rx_valid |->
            r.bus_action == ACT_RDACK || r.bus_action == ACT_RDNACK ||
            r.bus_action == ACT_STOP)
        else $error("received byte with wrong action");

    // no result word right after reset
    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind i2c_master_transfer_sequencer i2cms_checker u_i2cms_checker (.*);
